// ===== rtl/prb_pkg.sv =====
// Shared types and constants for the packet reorder buffer.
`default_nettype none

package prb_pkg;

    localparam int WINDOW_PACKETS_DEF = 64;
    localparam int PAYLOAD_BYTES_DEF  = 2;
    localparam int SEQ_W              = 32;
    localparam int BYTE_W             = 8;

    // Item kind decoded from the op field
    typedef enum logic {
        OP_RECEIVE = 1'b0,
        OP_DELIVER = 1'b1
    } t_op;

    // Classified command word queued between front and back
    typedef struct packed {
        t_op               op;
        logic [SEQ_W-1:0]  seq;
        logic [BYTE_W-1:0] byte_first;
        logic [BYTE_W-1:0] byte_second;
    } t_cmd;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RUN  = 2'd1,
        S_OUT  = 2'd2
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/prb_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module prb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/prb_front.sv =====
// Front end: accepts input words, classifies them and queues commands.
`default_nettype none

module prb_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_op,
    input  wire logic [prb_pkg::SEQ_W-1:0]     i_sequence_req,
    input  wire logic [prb_pkg::BYTE_W-1:0]    i_byte_first,
    input  wire logic [prb_pkg::BYTE_W-1:0]    i_byte_second,
    output logic                               o_cmd_valid,
    output prb_pkg::t_cmd                      o_cmd,
    input  wire logic                          i_cmd_ready
);

    import prb_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       push;
    logic       pop;
    t_cmd       in_cmd;

    // Classify the incoming word
    always_comb begin
        in_cmd.op          = t_op'(i_op);
        in_cmd.seq         = i_sequence_req;
        in_cmd.byte_first  = i_byte_first;
        in_cmd.byte_second = i_byte_second;
    end

    assign o_ready     = (r_count != 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    // Advance queue pointers and count
    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the queued word
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/prb_back.sv =====
// Back end: window bookkeeping, payload store and in-order delivery.
`default_nettype none

module prb_back #(
    parameter int WINDOW_PACKETS = prb_pkg::WINDOW_PACKETS_DEF,
    parameter int PAYLOAD_BYTES  = prb_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_valid,
    input  wire prb_pkg::t_cmd                 i_cmd,
    output logic                               o_cmd_ready,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [prb_pkg::SEQ_W-1:0]     o_out_sequence,
    output logic      [prb_pkg::BYTE_W-1:0]    o_out_first,
    output logic      [prb_pkg::BYTE_W-1:0]    o_out_second,
    output logic                               o_final_in_run
);

    import prb_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW_PACKETS);
    localparam int RUN_W  = $clog2(WINDOW_PACKETS + 1);
    localparam int DATA_W = BYTE_W * PAYLOAD_BYTES;

    t_state                r_state, n_state;
    logic [SEQ_W-1:0]      r_base, n_base;
    logic [SLOT_W-1:0]     r_base_slot, n_base_slot;
    logic [WINDOW_PACKETS-1:0] r_win, n_win;
    logic [RUN_W-1:0]      r_run, n_run;
    logic [SEQ_W-1:0]      r_out_seq, n_out_seq;
    logic                  r_out_last, n_out_last;

    logic [SEQ_W-1:0]      offset;
    logic                  in_window;
    logic [SLOT_W:0]       slot_sum;
    logic [SLOT_W-1:0]     rx_slot;
    logic [RUN_W-1:0]      first_zero;
    logic                  do_issue;
    logic                  ram_we;
    logic                  ram_re;
    logic [DATA_W-1:0]     ram_wr_data;
    logic [DATA_W-1:0]     ram_rd_data;

    // Locate the packet inside the window; the ring slot wraps at the window size
    assign offset    = i_cmd.seq - r_base;
    assign in_window = (offset < SEQ_W'(WINDOW_PACKETS));
    assign slot_sum  = {1'b0, r_base_slot} + {1'b0, offset[SLOT_W-1:0]};
    assign rx_slot   = (slot_sum >= (SLOT_W+1)'(WINDOW_PACKETS))
                     ? SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW_PACKETS))
                     : slot_sum[SLOT_W-1:0];

    // Find the first missing packet from the base; all present gives the full window
    always_comb begin
        first_zero = RUN_W'(WINDOW_PACKETS);
        for (int i = WINDOW_PACKETS - 1; i >= 0; i--) begin
            if (!r_win[i]) begin
                first_zero = RUN_W'(i);
            end
        end
    end

    // Sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_base_slot = r_base_slot;
        n_win       = r_win;
        n_run       = r_run;
        n_out_seq   = r_out_seq;
        n_out_last  = r_out_last;
        o_cmd_ready = 1'b0;
        ram_we      = 1'b0;
        do_issue    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    if (i_cmd.op == OP_RECEIVE) begin
                        // store in-window packets, drop the rest
                        if (in_window) begin
                            ram_we                       = 1'b1;
                            n_win[offset[SLOT_W-1:0]]    = 1'b1;
                            n_state                      = S_RUN;
                        end
                    end else if (r_run != '0) begin
                        do_issue = 1'b1;
                    end
                end
            end
            S_RUN: begin
                n_run   = first_zero;
                n_state = S_IDLE;
            end
            S_OUT: begin
                if (i_ready) begin
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        do_issue = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Read the base slot, then slide the window by one packet
        if (do_issue) begin
            n_out_seq   = r_base;
            n_out_last  = (r_run == RUN_W'(1));
            n_base      = r_base + 1'b1;
            n_base_slot = (r_base_slot == SLOT_W'(WINDOW_PACKETS - 1))
                        ? '0 : r_base_slot + 1'b1;
            n_win       = r_win >> 1;
            n_run       = r_run - 1'b1;
            n_state     = S_OUT;
        end
    end

    assign ram_re = do_issue;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_base_slot <= '0;
            r_win       <= '0;
            r_run       <= '0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_base_slot <= n_base_slot;
            r_win       <= n_win;
            r_run       <= n_run;
        end
    end

    // Output word fields
    always_ff @(posedge i_clk) begin
        r_out_seq  <= n_out_seq;
        r_out_last <= n_out_last;
    end

    // Pack and unpack the payload by configured byte count
    generate
        if (PAYLOAD_BYTES > 1) begin : g_two_bytes
            assign ram_wr_data  = {i_cmd.byte_second, i_cmd.byte_first};
            assign o_out_second = ram_rd_data[2*BYTE_W-1:BYTE_W];
        end else begin : g_one_byte
            assign ram_wr_data  = i_cmd.byte_first;
            assign o_out_second = '0;
        end
    endgenerate

    prb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_PACKETS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (rx_slot),
        .i_wr_data (ram_wr_data),
        .i_re      (ram_re),
        .i_rd_addr (r_base_slot),
        .o_rd_data (ram_rd_data)
    );

    assign o_valid        = (r_state == S_OUT);
    assign o_out_sequence = r_out_seq;
    assign o_out_first    = ram_rd_data[BYTE_W-1:0];
    assign o_final_in_run = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/packet_reorder_buffer.sv =====
// Top level of the packet reorder buffer.
//
//  Channel   Direction  Handshake           Word fields
//  input     in         i_valid / o_ready   i_op, i_sequence_req, i_byte_first, i_byte_second
//  output    out        o_valid / i_ready   o_out_sequence, o_out_first, o_out_second,
//                                           o_final_in_run
//
// A two-word command queue separates the front end from the back end.
// Receive: in the back end, S_IDLE does the store write and bitmap update, then
// S_RUN the find-first-zero that recomputes the run. Deliver: S_IDLE reads the
// first packet; each word taken in S_OUT reads the next until the run ends.
// Reset clears the window bitmap at once; no clearing pass is needed.
// Output stalls hold the back end; the queue keeps taking words until it fills.
`default_nettype none

module packet_reorder_buffer #(
    parameter int WINDOW_PACKETS = prb_pkg::WINDOW_PACKETS_DEF,
    parameter int PAYLOAD_BYTES  = prb_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_op,
    input  wire logic [prb_pkg::SEQ_W-1:0]     i_sequence_req,
    input  wire logic [prb_pkg::BYTE_W-1:0]    i_byte_first,
    input  wire logic [prb_pkg::BYTE_W-1:0]    i_byte_second,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [prb_pkg::SEQ_W-1:0]     o_out_sequence,
    output logic      [prb_pkg::BYTE_W-1:0]    o_out_first,
    output logic      [prb_pkg::BYTE_W-1:0]    o_out_second,
    output logic                               o_final_in_run
);

    import prb_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    // Accept and classify
    prb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_sequence_req (i_sequence_req),
        .i_byte_first   (i_byte_first),
        .i_byte_second  (i_byte_second),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_ready    (cmd_ready)
    );

    // Execute against the window
    prb_back #(
        .WINDOW_PACKETS (WINDOW_PACKETS),
        .PAYLOAD_BYTES  (PAYLOAD_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_ready    (cmd_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_sequence (o_out_sequence),
        .o_out_first    (o_out_first),
        .o_out_second   (o_out_second),
        .o_final_in_run (o_final_in_run)
    );

endmodule

`default_nettype wire

// ===== sim/packet_reorder_buffer_check.sv =====
// Checker for the packet reorder buffer: watches both channels, predicts delivered words and compares.
module packet_reorder_buffer_check #(
    parameter int WINDOW_PACKETS = prb_pkg::WINDOW_PACKETS_DEF,
    parameter int PAYLOAD_BYTES  = prb_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic                       o_ready,
    input  wire logic                       i_op,
    input  wire logic [prb_pkg::SEQ_W-1:0]  i_sequence_req,
    input  wire logic [prb_pkg::BYTE_W-1:0] i_byte_first,
    input  wire logic [prb_pkg::BYTE_W-1:0] i_byte_second,
    input  wire logic                       o_valid,
    input  wire logic                       i_ready,
    input  wire logic [prb_pkg::SEQ_W-1:0]  o_out_sequence,
    input  wire logic [prb_pkg::BYTE_W-1:0] o_out_first,
    input  wire logic [prb_pkg::BYTE_W-1:0] o_out_second,
    input  wire logic                       o_final_in_run,
    output int                              o_mismatch_count,
    output int                              o_due_count,
    output logic [prb_pkg::SEQ_W-1:0]       o_window_base
);

    import prb_pkg::*;

    // One delivered packet as it should leave the block
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [BYTE_W-1:0] byte_first;
        logic [BYTE_W-1:0] byte_second;
        logic              final_in_run;
    } t_delivered;

    // Mirror of the window state
    logic [SEQ_W-1:0]      base_seq;
    logic [SEQ_W-1:0]      newest_seq;
    int                    run_count;
    logic                  slot_full [WINDOW_PACKETS];
    logic [2*BYTE_W-1:0]   slot_payload [WINDOW_PACKETS];

    t_delivered            due_packets [$];
    int                    mismatches = 0;

    function automatic int slot_of(input logic [SEQ_W-1:0] seq);
        return int'(seq % SEQ_W'(WINDOW_PACKETS));
    endfunction

    task automatic note_mismatch(input string what, input logic [SEQ_W-1:0] want,
                                 input logic [SEQ_W-1:0] got);
        mismatches++;
        $error("%s: expected %0h, got %0h", what, want, got);
    endtask

    // Store a received packet and grow the contiguous run from the base
    task automatic stash_packet(input logic [SEQ_W-1:0] seq, input logic [BYTE_W-1:0] b_first,
                                input logic [BYTE_W-1:0] b_second);
        logic [SEQ_W-1:0] offset;
        logic [SEQ_W-1:0] newest_off;
        int               slot;
        offset     = seq - base_seq;
        newest_off = newest_seq - base_seq;
        // drop anything outside the window, behind the base included
        if (offset >= SEQ_W'(WINDOW_PACKETS))
            return;
        slot = slot_of(seq);
        slot_payload[slot] = {(PAYLOAD_BYTES < 2) ? {BYTE_W{1'b0}} : b_second, b_first};
        slot_full[slot]    = 1'b1;
        if (newest_off >= SEQ_W'(WINDOW_PACKETS) || offset > newest_off)
            newest_seq = seq;
        while (run_count < WINDOW_PACKETS && slot_full[slot_of(base_seq + SEQ_W'(run_count))])
            run_count++;
    endtask

    // Emit the contiguous run in order, then free its slots and advance
    task automatic release_run();
        logic [SEQ_W-1:0] seq;
        int               slot;
        t_delivered       pkt;
        for (int k = 0; k < run_count; k++) begin
            seq  = base_seq + SEQ_W'(k);
            slot = slot_of(seq);
            pkt.seq          = seq;
            pkt.byte_first   = slot_payload[slot][BYTE_W-1:0];
            pkt.byte_second  = (PAYLOAD_BYTES < 2) ? '0 : slot_payload[slot][2*BYTE_W-1:BYTE_W];
            pkt.final_in_run = (k == run_count - 1);
            due_packets.push_back(pkt);
            slot_full[slot] = 1'b0;
        end
        base_seq  = base_seq + SEQ_W'(run_count);
        run_count = 0;
    endtask

    always @(posedge i_clk) begin : watch
        t_delivered want;
        if (!i_rst_n) begin
            base_seq   = '0;
            newest_seq = '0;
            run_count  = 0;
            foreach (slot_full[i])
                slot_full[i] = 1'b0;
            due_packets.delete();
        end else begin
            // compare each delivered word against the oldest prediction
            if (o_valid && i_ready) begin
                if (due_packets.size() == 0) begin
                    note_mismatch("unexpected word, out_sequence", '0, o_out_sequence);
                end else begin
                    want = due_packets.pop_front();
                    if (o_out_sequence !== want.seq)
                        note_mismatch("out_sequence", want.seq, o_out_sequence);
                    if (o_out_first !== want.byte_first)
                        note_mismatch("out_first", SEQ_W'(want.byte_first),
                                      SEQ_W'(o_out_first));
                    if (o_out_second !== want.byte_second)
                        note_mismatch("out_second", SEQ_W'(want.byte_second),
                                      SEQ_W'(o_out_second));
                    if (o_final_in_run !== want.final_in_run)
                        note_mismatch("final_in_run", SEQ_W'(want.final_in_run),
                                      SEQ_W'(o_final_in_run));
                end
            end
            // predict from each accepted input word
            if (i_valid && o_ready) begin
                if (i_op == OP_RECEIVE)
                    stash_packet(i_sequence_req, i_byte_first, i_byte_second);
                else
                    release_run();
            end
        end
        o_mismatch_count <= mismatches;
        o_due_count      <= due_packets.size();
        o_window_base    <= base_seq;
    end

endmodule

// ===== sim/packet_reorder_buffer_test.sv =====
// Testbench top for the packet reorder buffer: clock, reset, stimulus and verdict.
module packet_reorder_buffer_test;
    import prb_pkg::*;

    localparam int WINDOW          = WINDOW_PACKETS_DEF;
    localparam int RANDOM_ITEMS    = 500;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 64;
    localparam int CYCLE_LIMIT     = 600000;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              o_ready;
    logic              i_op           = OP_RECEIVE;
    logic [SEQ_W-1:0]  i_sequence_req = '0;
    logic [BYTE_W-1:0] i_byte_first   = '0;
    logic [BYTE_W-1:0] i_byte_second  = '0;
    logic              o_valid;
    logic              i_ready        = 1'b0;
    logic [SEQ_W-1:0]  o_out_sequence;
    logic [BYTE_W-1:0] o_out_first;
    logic [BYTE_W-1:0] o_out_second;
    logic              o_final_in_run;

    int                mismatch_count;
    int                due_count;
    logic [SEQ_W-1:0]  window_base_seen;
    int unsigned       words_out = 0;
    int unsigned       cycle_count = 0;

    packet_reorder_buffer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_sequence_req (i_sequence_req),
        .i_byte_first   (i_byte_first),
        .i_byte_second  (i_byte_second),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_sequence (o_out_sequence),
        .o_out_first    (o_out_first),
        .o_out_second   (o_out_second),
        .o_final_in_run (o_final_in_run)
    );

    packet_reorder_buffer_check u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_sequence_req   (i_sequence_req),
        .i_byte_first     (i_byte_first),
        .i_byte_second    (i_byte_second),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_sequence   (o_out_sequence),
        .o_out_first      (o_out_first),
        .o_out_second     (o_out_second),
        .o_final_in_run   (o_final_in_run),
        .o_mismatch_count (mismatch_count),
        .o_due_count      (due_count),
        .o_window_base    (window_base_seen)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Count delivered words and bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && i_ready)
            words_out <= words_out + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL packet_reorder_buffer");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none at all when calm
    function automatic int idle_len(input bit calm);
        int pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one word; a relative sequence is resolved against the current base after the gap
    task automatic send_word(input t_op op, input bit relative, input logic [SEQ_W-1:0] seq,
                             input logic [BYTE_W-1:0] b_first,
                             input logic [BYTE_W-1:0] b_second, input bit calm);
        int gap;
        gap = idle_len(calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_sequence_req <= relative ? window_base_seen + seq : seq;
        i_byte_first   <= b_first;
        i_byte_second  <= b_second;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // Stop offering and wait for every predicted word to come out
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (due_count != 0)
            @(posedge i_clk);
    endtask

    // Output side: random back-pressure plus long hold-offs to fill the block
    initial begin : sink
        int gap;
        int span;
        int holds;
        bit calm;
        span  = 0;
        holds = 0;
        calm  = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (span == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                span = $urandom_range(20, 120);
            end
            span--;
            if (holds < 2 && words_out >= 40 + 260 * holds) begin
                gap = HOLD_OFF_CYCLES;
                holds++;
            end else begin
                gap = idle_len(calm);
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Input side: directed cases, then shuffled bursts with noise
    initial begin : source
        int          n;
        int          idx;
        int          split;
        int          bursts;
        int          packets_sent;
        int unsigned offsets [$];
        int unsigned swap;
        bit          calm;

        bursts       = 0;
        packets_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty deliver, then a two-packet run arriving backwards
        send_word(OP_DELIVER, 1'b0, '1, 8'hFF, 8'hFF, 1'b1);
        send_word(OP_RECEIVE, 1'b0, 32'd1, 8'hFF, 8'h00, 1'b1);
        send_word(OP_RECEIVE, 1'b0, 32'd0, 8'h00, 8'hFF, 1'b1);
        send_word(OP_DELIVER, 1'b0, '0, 8'h00, 8'h00, 1'b1);
        // behind the base, wrapped behind, one past the window, last slot of the window
        send_word(OP_RECEIVE, 1'b0, 32'd0, 8'h12, 8'h34, 1'b0);
        send_word(OP_RECEIVE, 1'b0, 32'hFFFF_FFFF, 8'h56, 8'h78, 1'b0);
        send_word(OP_RECEIVE, 1'b0, 32'd2 + WINDOW, 8'h9A, 8'hBC, 1'b0);
        send_word(OP_RECEIVE, 1'b0, 32'd1 + WINDOW, 8'hA5, 8'h5A, 1'b0);
        // duplicate overwrites, then a run of one stopped by a gap
        send_word(OP_RECEIVE, 1'b0, 32'd2, 8'h11, 8'h22, 1'b1);
        send_word(OP_RECEIVE, 1'b0, 32'd2, 8'h33, 8'h44, 1'b1);
        send_word(OP_RECEIVE, 1'b0, 32'd4, 8'h55, 8'h66, 1'b1);
        send_word(OP_DELIVER, 1'b0, 32'h8000_0000, 8'h00, 8'h00, 1'b1);
        send_word(OP_RECEIVE, 1'b0, 32'd3, 8'h77, 8'h88, 1'b0);
        send_word(OP_DELIVER, 1'b0, '0, 8'h00, 8'h00, 1'b0);
        send_word(OP_DELIVER, 1'b0, '0, 8'h00, 8'h00, 1'b0);
        send_word(OP_RECEIVE, 1'b0, 32'h8000_0005, 8'hFF, 8'hFF, 1'b0);
        hold_until_drained();

        while (packets_sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            n = ($urandom_range(0, 19) == 0) ? WINDOW : $urandom_range(1, 10);
            offsets.delete();
            for (int k = 0; k < n; k++)
                offsets.push_back(k);
            // shuffle, and sometimes leave a hole so the run stops short
            for (int k = n - 1; k > 0; k--) begin
                idx          = $urandom_range(0, k);
                swap         = offsets[k];
                offsets[k]   = offsets[idx];
                offsets[idx] = swap;
            end
            if (n > 1 && $urandom_range(0, 4) == 0)
                offsets.delete($urandom_range(0, n - 1));
            split = ($urandom_range(0, 5) == 0) ? offsets.size() / 2 : -1;

            foreach (offsets[k]) begin
                if (k == split) begin
                    send_word(OP_DELIVER, 1'b0, $urandom(), 8'($urandom), 8'($urandom), calm);
                    packets_sent++;
                end
                // sprinkle noise: random, behind, beyond, duplicate
                case ($urandom_range(0, 11))
                    0: begin
                        send_word(OP_RECEIVE, 1'b0, $urandom(), 8'($urandom), 8'($urandom),
                                  calm);
                        packets_sent++;
                    end
                    1: begin
                        send_word(OP_RECEIVE, 1'b1, 32'd0 - $urandom_range(1, 80),
                                  8'($urandom), 8'($urandom), calm);
                        packets_sent++;
                    end
                    2: begin
                        send_word(OP_RECEIVE, 1'b1, WINDOW + $urandom_range(0, 40),
                                  8'($urandom), 8'($urandom), calm);
                        packets_sent++;
                    end
                    3: if (k > 0) begin
                        send_word(OP_RECEIVE, 1'b1, offsets[$urandom_range(0, k - 1)],
                                  8'($urandom), 8'($urandom), calm);
                        packets_sent++;
                    end
                    default: ;
                endcase
                send_word(OP_RECEIVE, 1'b1, offsets[k], 8'($urandom), 8'($urandom), calm);
                packets_sent++;
            end
            send_word(OP_DELIVER, 1'b0, $urandom(), 8'($urandom), 8'($urandom), calm);
            packets_sent++;
            if ($urandom_range(0, 7) == 0) begin
                send_word(OP_DELIVER, 1'b0, $urandom(), 8'($urandom), 8'($urandom), calm);
                packets_sent++;
            end
            bursts++;
            if (bursts % 7 == 0)
                hold_until_drained();
        end

        // wait out the last words, then let the block settle
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && due_count == 0)
            $display("PASS packet_reorder_buffer");
        else
            $display("FAIL packet_reorder_buffer");
        $finish;
    end

endmodule
